@@ sv/tea_block_cipher_unit_macros.svh @@
// ----------------------------------------------------------------------------
// TEA block cipher unit assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef TEA_BLOCK_CIPHER_UNIT_MACROS_SVH
`define TEA_BLOCK_CIPHER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tea_block_cipher_unit: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tea_block_cipher_unit: next-cycle check failed");

`endif

@@ sv/tbc_pkg.sv @@
// ----------------------------------------------------------------------------
// TEA block cipher package
// Widths, register indexes, round constants and key bundle type.
// ----------------------------------------------------------------------------
package tbc_pkg;

   localparam int WORD_W      = 32;
   localparam int BLOCK_W     = 64;
   localparam int CSR_INDEX_W = 3;

   localparam int ROUNDS_DEFAULT = 32;

   localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD3 = 3'd3;

   // Operation codes.
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] word0;
      logic [WORD_W-1:0] word1;
      logic [WORD_W-1:0] word2;
      logic [WORD_W-1:0] word3;
   } key_type;

   // Round sum count*delta modulo 2^32, evaluated at elaboration only.
   function automatic logic [WORD_W-1:0] round_sum(input int unsigned count);
      logic [2*WORD_W-1:0] product;
      product = (2*WORD_W)'(count) * (2*WORD_W)'(DELTA);
      return product[WORD_W-1:0];
   endfunction

endpackage

@@ sv/tbc_half_round.sv @@
// ----------------------------------------------------------------------------
// TEA half-round stage
// One registered half of a Feistel cycle, for either direction.
// ----------------------------------------------------------------------------
module tbc_half_round #(
   parameter logic [tbc_pkg::WORD_W-1:0] SUM_ENC = tbc_pkg::DELTA,
   parameter logic [tbc_pkg::WORD_W-1:0] SUM_DEC = tbc_pkg::DELTA,
   parameter bit                         SECOND  = 1'b0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  tbc_pkg::key_type              key,
   input  logic                          valid_i,
   input  logic                          op_i,
   input  logic [tbc_pkg::BLOCK_W-1:0]   block_i,
   output logic                          valid_o,
   output logic                          op_o,
   output logic [tbc_pkg::BLOCK_W-1:0]   block_o
);

   localparam int W = tbc_pkg::WORD_W;

   logic                        valid_ff, valid_in;
   logic                        op_ff;
   logic [tbc_pkg::BLOCK_W-1:0] block_ff, block_in;

   logic          upper;
   logic [W-1:0]  src, dst, key_l, key_r, sum, mix, res;

   // Encryption updates the upper word first; decryption walks the cycle
   // backwards and updates the lower word first.
   always_comb begin
      if (op_i == tbc_pkg::OP_DECRYPT) begin
         upper = SECOND;
         sum   = SUM_DEC;
      end else begin
         upper = !SECOND;
         sum   = SUM_ENC;
      end
      src   = upper ? block_i[W-1:0] : block_i[2*W-1:W];
      dst   = upper ? block_i[2*W-1:W] : block_i[W-1:0];
      key_l = upper ? key.word0 : key.word2;
      key_r = upper ? key.word1 : key.word3;
      mix   = ((src << 4) + key_l) ^ (src + sum) ^ ((src >> 5) + key_r);
      res   = (op_i == tbc_pkg::OP_DECRYPT) ? (dst - mix) : (dst + mix);
      block_in = upper ? {res, src} : {src, res};
      valid_in = enable ? valid_i : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         op_ff    <= op_i;
         block_ff <= block_in;
      end
   end

   assign valid_o = valid_ff;
   assign op_o    = op_ff;
   assign block_o = block_ff;

endmodule

@@ sv/tea_block_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// TEA block cipher unit
// Pipelined TEA encrypt/decrypt of 64-bit blocks under a 128-bit key.
// ----------------------------------------------------------------------------
// Pipeline: one registered half-round stage per half of each round.
// Throughput: one block per cycle; the whole pipeline holds while a result
// waits under rsp_stall, set by the single shared advance enable.
// Reset: synchronous, clears all stage valid bits and the key to zero.
// Key writes are taken at any time outside reset.
module tea_block_cipher_unit #(
   parameter int ROUNDS = tbc_pkg::ROUNDS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [tbc_pkg::BLOCK_W-1:0]       req_block_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tbc_pkg::BLOCK_W-1:0]       rsp_block_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tbc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tbc_pkg::WORD_W-1:0]        csr_data
);

   localparam int STAGES = 2 * ROUNDS;

   tbc_pkg::key_type key_ff, key_in;

   logic                        enable;
   logic                        stage_valid [0:STAGES];
   logic                        stage_op    [0:STAGES];
   logic [tbc_pkg::BLOCK_W-1:0] stage_block [0:STAGES];

   assign csr_ready = !reset;

   always_comb begin
      key_in = key_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tbc_pkg::CSR_KEY_WORD0: key_in.word0 = csr_data;
            tbc_pkg::CSR_KEY_WORD1: key_in.word1 = csr_data;
            tbc_pkg::CSR_KEY_WORD2: key_in.word2 = csr_data;
            tbc_pkg::CSR_KEY_WORD3: key_in.word3 = csr_data;
            default: key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // The pipeline moves unless a finished result is held back.
   assign enable    = !(stage_valid[STAGES] && rsp_stall);
   assign req_stall = reset || !enable;

   assign stage_valid[0] = req_valid && !req_stall;
   assign stage_op[0]    = req_op;
   assign stage_block[0] = req_block_in;

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      localparam int RND = j / 2;
      localparam logic [tbc_pkg::WORD_W-1:0] S_ENC = tbc_pkg::round_sum(RND + 1);
      localparam logic [tbc_pkg::WORD_W-1:0] S_DEC = tbc_pkg::round_sum(ROUNDS - RND);

      tbc_half_round #(
         .SUM_ENC (S_ENC),
         .SUM_DEC (S_DEC),
         .SECOND  ((j % 2) == 1)
      ) u_half_round (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .key     (key_ff),
         .valid_i (stage_valid[j]),
         .op_i    (stage_op[j]),
         .block_i (stage_block[j]),
         .valid_o (stage_valid[j+1]),
         .op_o    (stage_op[j+1]),
         .block_o (stage_block[j+1])
      );
   end

   assign rsp_valid     = stage_valid[STAGES];
   assign rsp_block_out = stage_block[STAGES];

endmodule

@@ sv/tbc_checker.sv @@
// ----------------------------------------------------------------------------
// TEA block cipher unit checker
// Port-level assertions on handshakes and reset, bound to the top level.
// ----------------------------------------------------------------------------
`include "tea_block_cipher_unit_macros.svh"

module tbc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [tbc_pkg::BLOCK_W-1:0]       rsp_block_out,
   input logic                              csr_valid,
   input logic                              csr_ready
);

   // A held result stays put until it is transferred.
   `TBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_block_out))

   // The input side backs up only behind a held result.
   `TBC_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // Key writes are always taken outside reset.
   `TBC_ASSERT_SAME(a_csr_ready, clock, reset, csr_valid, csr_ready)

   // Nothing comes out in the first cycle after reset.
   `TBC_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

endmodule

bind tea_block_cipher_unit tbc_checker u_tbc_checker (.*);

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// TEA block cipher unit testbench
// Drives encrypt and decrypt blocks under several keys, first from a directed
// table and then at random, with random idling on both channels and a long
// result hold-off, and checks every result block against a built-in model or a known answer.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BLOCK_W      = tbc_pkg::BLOCK_W;
   localparam int WORD_W       = tbc_pkg::WORD_W;
   localparam int CSR_INDEX_W  = tbc_pkg::CSR_INDEX_W;
   localparam int TEA_ROUNDS   = tbc_pkg::ROUNDS_DEFAULT;
   localparam int PIPE_LATENCY = 2 * TEA_ROUNDS;
   localparam int LONG_HOLD    = 300;
   localparam int STALL_LIMIT  = 3000;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic               op;
      logic [BLOCK_W-1:0] block;
      logic               fixed;
      logic [BLOCK_W-1:0] fixed_out;
   } cipher_row_type;

   localparam int NUM_ROWS = 13;

   // Rows with the fixed flag carry a result known in advance: the all-zero
   // block under the all-zero reset key, and its inverse.
   cipher_row_type cipher_rows [NUM_ROWS] = '{
      '{tbc_pkg::OP_ENCRYPT, 64'h0000_0000_0000_0000, 1'b1, 64'h41ea_3a0a_94ba_a940},
      '{tbc_pkg::OP_DECRYPT, 64'h41ea_3a0a_94ba_a940, 1'b1, 64'h0000_0000_0000_0000},
      '{tbc_pkg::OP_ENCRYPT, 64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
      '{tbc_pkg::OP_DECRYPT, 64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
      '{tbc_pkg::OP_ENCRYPT, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
      '{tbc_pkg::OP_DECRYPT, 64'h0000_0000_0000_0001, 1'b0, 64'h0},
      '{tbc_pkg::OP_ENCRYPT, 64'h0000_0001_0000_0000, 1'b0, 64'h0},
      '{tbc_pkg::OP_ENCRYPT, 64'h0000_0000_ffff_ffff, 1'b0, 64'h0},
      '{tbc_pkg::OP_DECRYPT, 64'hffff_ffff_0000_0000, 1'b0, 64'h0},
      '{tbc_pkg::OP_ENCRYPT, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'h0},
      '{tbc_pkg::OP_DECRYPT, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
      '{tbc_pkg::OP_ENCRYPT, 64'h0123_4567_89ab_cdef, 1'b0, 64'h0},
      '{tbc_pkg::OP_DECRYPT, 64'h0123_4567_89ab_cdef, 1'b0, 64'h0}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_op;
   logic [BLOCK_W-1:0]     req_block_in;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [BLOCK_W-1:0]     rsp_block_out;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_data;

   tbc_pkg::key_type   key_shadow;
   logic [BLOCK_W-1:0] expected_blocks [$];
   int                 error_count;
   int                 quiet_cycles;
   bit                 tx_idling;
   bit                 rx_idling;
   bit                 hold_req;

   tea_block_cipher_unit #(
      .ROUNDS(TEA_ROUNDS)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_block_in (req_block_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_block_out(rsp_block_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [WORD_W-1:0] half_mix(input logic [WORD_W-1:0] w,
                                                  input logic [WORD_W-1:0] sum,
                                                  input logic [WORD_W-1:0] kl,
                                                  input logic [WORD_W-1:0] kr);
      return ((w << 4) + kl) ^ (w + sum) ^ ((w >> 5) + kr);
   endfunction

   function automatic logic [BLOCK_W-1:0] tea_cipher(input logic op,
                                                     input logic [BLOCK_W-1:0] block,
                                                     input tbc_pkg::key_type key);
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
      logic [WORD_W-1:0] sum;
      y = block[BLOCK_W-1:WORD_W];
      z = block[WORD_W-1:0];
      sum = '0;
      if (op == tbc_pkg::OP_ENCRYPT) begin
         for (int r = 0; r < TEA_ROUNDS; r++) begin
            sum += tbc_pkg::DELTA;
            y += half_mix(z, sum, key.word0, key.word1);
            z += half_mix(y, sum, key.word2, key.word3);
         end
      end else begin
         for (int r = 0; r < TEA_ROUNDS; r++) begin
            sum += tbc_pkg::DELTA;
         end
         for (int r = 0; r < TEA_ROUNDS; r++) begin
            z -= half_mix(y, sum, key.word2, key.word3);
            y -= half_mix(z, sum, key.word0, key.word1);
            sum -= tbc_pkg::DELTA;
         end
      end
      return {y, z};
   endfunction

   task automatic report_mismatch(input string what, input logic [BLOCK_W-1:0] exp_block,
                                  input logic [BLOCK_W-1:0] got_block);
      error_count++;
      if (error_count <= REPORT_MAX) begin
         $display("%0t: %s: expected %h, got %h", $realtime, what, exp_block, got_block);
      end
   endtask

   task automatic write_key(input logic [CSR_INDEX_W-1:0] index,
                            input logic [WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         tbc_pkg::CSR_KEY_WORD0: key_shadow.word0 = data;
         tbc_pkg::CSR_KEY_WORD1: key_shadow.word1 = data;
         tbc_pkg::CSR_KEY_WORD2: key_shadow.word2 = data;
         tbc_pkg::CSR_KEY_WORD3: key_shadow.word3 = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_key(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                           input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3);
      logic [CSR_INDEX_W-1:0] unused_index;
      write_key(tbc_pkg::CSR_KEY_WORD0, w0);
      write_key(tbc_pkg::CSR_KEY_WORD1, w1);
      write_key(tbc_pkg::CSR_KEY_WORD2, w2);
      write_key(tbc_pkg::CSR_KEY_WORD3, w3);
      // An index past the last key word must leave the key alone.
      unused_index = tbc_pkg::CSR_KEY_WORD3 + CSR_INDEX_W'($urandom_range(1, 4));
      write_key(unused_index, $urandom());
   endtask

   task automatic send_block(input logic op, input logic [BLOCK_W-1:0] block,
                             input logic fixed, input logic [BLOCK_W-1:0] fixed_out);
      if (tx_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_block_in <= block;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_blocks.push_back(fixed ? fixed_out : tea_cipher(op, block, key_shadow));
   endtask

   // Lowers valid and waits until every expected block has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
   endtask

   function automatic logic [BLOCK_W-1:0] random_block();
      logic [BLOCK_W-1:0] one_hot;
      one_hot = 64'd1 << $urandom_range(0, BLOCK_W - 1);
      case ($urandom_range(0, 9))
         0: return one_hot;
         1: return ~one_hot;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // Single blocks of either operation, each followed half the time by a round
   // trip transfer that runs the opposite operation on the block's result.
   task automatic send_random_blocks(input int count);
      logic [BLOCK_W-1:0] plain;
      logic               first_op;
      int                 sent;
      sent = 0;
      while (sent < count) begin
         plain    = random_block();
         first_op = logic'($urandom_range(0, 1));
         send_block(first_op, plain, 1'b0, '0);
         sent++;
         if ($urandom_range(0, 1) == 1) begin
            send_block(~first_op, tea_cipher(first_op, plain, key_shadow), 1'b0, '0);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blocks.size() == 0) begin
            report_mismatch("result with none expected", '0, rsp_block_out);
         end else if (rsp_block_out !== expected_blocks[0]) begin
            report_mismatch("block_out mismatch", expected_blocks[0], rsp_block_out);
            void'(expected_blocks.pop_front());
         end else begin
            void'(expected_blocks.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("[tea_block_cipher_unit] ERROR");
            $finish;
         end
      end
   end

   // Result side: short random stalls, or one long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_req = 1'b0;
         end else if (rx_idling && $urandom_range(0, 1) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = tbc_pkg::OP_ENCRYPT;
      req_block_in = '0;
      csr_valid    = 1'b0;
      csr_index    = tbc_pkg::CSR_KEY_WORD0;
      csr_data     = '0;
      key_shadow   = '0;
      error_count  = 0;
      tx_idling    = 1'b1;
      rx_idling    = 1'b1;
      hold_req     = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The key is still at its reset value here.
      for (int i = 0; i < NUM_ROWS; i++) begin
         send_block(cipher_rows[i].op, cipher_rows[i].block,
                    cipher_rows[i].fixed, cipher_rows[i].fixed_out);
      end
      drain_results();

      load_key('1, '1, '1, '1);
      send_random_blocks(50);
      drain_results();

      // Back-to-back transfers against a long result hold-off fill the
      // pipeline until the input stalls.
      load_key($urandom(), $urandom(), $urandom(), $urandom());
      tx_idling = 1'b0;
      hold_req  = 1'b1;
      send_random_blocks(80);
      tx_idling = 1'b1;
      send_random_blocks(60);
      drain_results();

      load_key(32'h0000_0001, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff);
      send_random_blocks(60);
      drain_results();

      load_key($urandom(), $urandom(), $urandom(), $urandom());
      send_random_blocks(60);
      drain_results();

      load_key($urandom(), $urandom(), $urandom(), $urandom());
      tx_idling = 1'b0;
      rx_idling = 1'b0;
      send_random_blocks(50);
      drain_results();

      repeat (PIPE_LATENCY + 16) @(posedge clock);
      while (expected_blocks.size() != 0) begin
         report_mismatch("result never arrived", expected_blocks.pop_front(), 'x);
      end
      if (error_count == 0) begin
         $display("[tea_block_cipher_unit] OK");
      end else begin
         $display("[tea_block_cipher_unit] ERROR");
      end
      $finish;
   end

endmodule
